@@ src/pil_pkg.sv @@
// -----------------------------------------------------------------------------
// pil_pkg
// Types and codes shared by the positional integer list core.
// -----------------------------------------------------------------------------
package pil_pkg;

	localparam int PIL_CAPACITY = 64;

	localparam logic [3:0] CMD_APPEND    = 4'd0;
	localparam logic [3:0] CMD_INSERT    = 4'd1;
	localparam logic [3:0] CMD_PUT       = 4'd2;
	localparam logic [3:0] CMD_REMOVE    = 4'd3;
	localparam logic [3:0] CMD_READ      = 4'd4;
	localparam logic [3:0] CMD_POP_FIRST = 4'd5;
	localparam logic [3:0] CMD_POP_LAST  = 4'd6;
	localparam logic [3:0] CMD_CLEAR     = 4'd7;
	localparam logic [3:0] CMD_RESIZE    = 4'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic        [3:0]  cmd;
		logic signed [31:0] value;
		logic        [5:0]  position;
		logic        [6:0]  new_length;
		logic signed [31:0] fill_value;
	} pil_req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		logic        [6:0]  count;
		logic        [1:0]  status;
	} pil_rsp_t;

endpackage

@@ src/positional_integer_list_core.sv @@
// -----------------------------------------------------------------------------
// positional_integer_list_core
// Ordered list of up to CAPACITY signed words in a single-port memory, with
// append, insert, put, remove, read, pop, clear and resize commands.
// -----------------------------------------------------------------------------
// channel  signals                  transaction
// req      req_valid/req_ready/req  one command
// rsp      rsp_valid/rsp_ready/rsp  one result per command
//
// one command at a time; a sequencer drives one memory port, one access a cycle.
// read, pop last: read, capture, result; append, put in range, resize down: fill, result.
// insert in range: read/write per word moved up, then write; remove/pop first: read, capture,
// read/write per word moved down; put/insert past the end, resize up: a write per gap slot;
// errors, clear, unknown: result only; no clearing pass after reset; the result register
// lets a new command in while the previous result is still waiting to be taken.
// -----------------------------------------------------------------------------
module positional_integer_list_core
	import pil_pkg::*;
#(
	parameter int CAPACITY = PIL_CAPACITY
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  pil_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output pil_rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int XW = ((LW > 7) ? LW : 7) + 1;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FILL   = 4'd1;
	localparam logic [3:0] S_SU_RD  = 4'd2;
	localparam logic [3:0] S_SU_WR  = 4'd3;
	localparam logic [3:0] S_TK_RD  = 4'd4;
	localparam logic [3:0] S_TK_CAP = 4'd5;
	localparam logic [3:0] S_SD_RD  = 4'd6;
	localparam logic [3:0] S_SD_WR  = 4'd7;
	localparam logic [3:0] S_RESP   = 4'd8;

	logic [3:0]         state_q;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      ptr_q;
	logic [LW-1:0]      fend_q;
	logic [LW-1:0]      newlen_q;
	logic [LW-1:0]      pos_q;
	logic               wlast_q;
	logic               take_q;
	logic signed [31:0] value_q;
	logic signed [31:0] fword_q;
	logic signed [31:0] data_q;
	logic [1:0]         status_q;
	logic               rsp_valid_q;
	pil_rsp_t           rsp_q;

	logic [31:0]        mem [CAPACITY];
	logic [31:0]        rdata_q;
	logic               mem_we;
	logic [AW-1:0]      mem_addr;
	logic [31:0]        mem_wdata;

	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      len_x;
	logic [XW-1:0]      tgt_x;
	logic [XW-1:0]      cap_x;
	logic [LW-1:0]      ptr_p1;
	logic [LW-1:0]      ptr_m1;
	logic               fill_go;
	logic               accept;
	logic               rsp_free;

	assign pos_x   = XW'(req.position);
	assign len_x   = XW'(len_q);
	assign tgt_x   = XW'(req.new_length);
	assign cap_x   = XW'(CAPACITY);
	assign ptr_p1  = ptr_q + 1'b1;
	assign ptr_m1  = ptr_q - 1'b1;
	assign fill_go = ptr_q < fend_q;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = ptr_q[AW-1:0];
		mem_wdata = rdata_q;
		unique case (state_q)
			S_FILL: begin
				mem_we    = fill_go || wlast_q;
				mem_wdata = fill_go ? fword_q : value_q;
			end
			S_SU_RD: mem_addr = ptr_m1[AW-1:0];
			S_SU_WR: mem_we = 1'b1;
			S_SD_WR: begin
				mem_we   = 1'b1;
				mem_addr = ptr_m1[AW-1:0];
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q   <= '0;
						status_q <= ST_OK;
						value_q  <= req.value;
						fword_q  <= req.fill_value;
						pos_q    <= LW'(pos_x);
						wlast_q  <= 1'b1;
						state_q  <= S_RESP;
						unique case (req.cmd) inside
							CMD_APPEND: begin
								if (len_x >= cap_x) begin
									status_q <= ST_FULL;
								end else begin
									ptr_q    <= len_q;
									fend_q   <= len_q;
									newlen_q <= len_q + 1'b1;
									state_q  <= S_FILL;
								end
							end
							CMD_INSERT, CMD_PUT: begin
								if (pos_x < len_x) begin
									if (req.cmd == CMD_PUT) begin
										ptr_q    <= LW'(pos_x);
										fend_q   <= LW'(pos_x);
										newlen_q <= len_q;
										state_q  <= S_FILL;
									end else if (len_x >= cap_x) begin
										status_q <= ST_FULL;
									end else begin
										ptr_q    <= len_q;
										fend_q   <= LW'(pos_x);
										newlen_q <= len_q + 1'b1;
										state_q  <= S_SU_RD;
									end
								end else if (pos_x >= cap_x) begin
									status_q <= ST_FULL;
								end else begin
									// gap is zero for insert, fill word for put
									ptr_q    <= len_q;
									fend_q   <= LW'(pos_x);
									newlen_q <= LW'(pos_x + 1'b1);
									if (req.cmd == CMD_INSERT) begin
										fword_q <= '0;
									end
									state_q  <= S_FILL;
								end
							end
							CMD_REMOVE, CMD_READ: begin
								if (pos_x < len_x) begin
									ptr_q   <= LW'(pos_x);
									take_q  <= (req.cmd == CMD_REMOVE);
									state_q <= S_TK_RD;
								end else begin
									status_q <= ST_RANGE;
								end
							end
							CMD_POP_FIRST, CMD_POP_LAST: begin
								if (len_q != '0) begin
									ptr_q   <= (req.cmd == CMD_POP_FIRST) ? '0 : len_q - 1'b1;
									take_q  <= 1'b1;
									state_q <= S_TK_RD;
								end else begin
									status_q <= ST_RANGE;
								end
							end
							CMD_CLEAR: begin
								len_q <= '0;
							end
							CMD_RESIZE: begin
								if (tgt_x > cap_x) begin
									status_q <= ST_FULL;
								end else begin
									// shrinking skips straight to the length update
									ptr_q    <= len_q;
									fend_q   <= LW'(tgt_x);
									newlen_q <= LW'(tgt_x);
									wlast_q  <= 1'b0;
									state_q  <= S_FILL;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_FILL: begin
					if (fill_go) begin
						ptr_q <= ptr_p1;
					end else begin
						len_q   <= newlen_q;
						state_q <= S_RESP;
					end
				end
				S_SU_RD: begin
					state_q <= S_SU_WR;
				end
				S_SU_WR: begin
					ptr_q   <= ptr_m1;
					// last move done when the hole reaches the insert position
					state_q <= (ptr_m1 == pos_q) ? S_FILL : S_SU_RD;
				end
				S_TK_RD: begin
					state_q <= S_TK_CAP;
				end
				S_TK_CAP: begin
					data_q <= rdata_q;
					if (take_q && (ptr_p1 < len_q)) begin
						ptr_q   <= ptr_p1;
						state_q <= S_SD_RD;
					end else begin
						if (take_q) begin
							len_q <= len_q - 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_SD_RD: begin
					state_q <= S_SD_WR;
				end
				S_SD_WR: begin
					if (ptr_p1 < len_q) begin
						ptr_q   <= ptr_p1;
						state_q <= S_SD_RD;
					end else begin
						len_q   <= len_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_q.data_out <= data_q;
						rsp_q.count    <= 7'(len_q);
						rsp_q.status   <= status_q;
						rsp_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LW'(CAPACITY))
		else $error("list length above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == S_FILL)) |-> (ptr_q < LW'(CAPACITY)))
		else $error("memory write beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("second command taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != ST_OK)) |-> (rsp.data_out == 32'sd0))
		else $error("error result carries data");

endmodule
